[hdl/sscv_pkg.sv]
`default_nettype none

package sscv_pkg;

    localparam int MAX_AXES = 8;
    localparam int CNT_W    = $clog2(MAX_AXES + 1);

    localparam int LEN_W    = 31;
    localparam int IDX_W    = 32;
    localparam int WIDE_W   = 64;

    localparam int DIV_STEPS = LEN_W;
    localparam int DIV_CNT_W = $clog2(DIV_STEPS + 1);

    localparam int Q_DEPTH  = 2;
    localparam int Q_PTR_W  = $clog2(Q_DEPTH);
    localparam int Q_CNT_W  = $clog2(Q_DEPTH + 1);

    typedef struct packed {
        logic [LEN_W-1:0]        axis_size;
        logic signed [IDX_W-1:0] axis_stride;
        logic signed [IDX_W-1:0] slice_start;
        logic signed [IDX_W-1:0] slice_stop;
        logic signed [IDX_W-1:0] slice_step;
        logic                    last_axis;
    } in_item_t;

    typedef struct packed {
        logic [LEN_W-1:0]         sliced_length;
        logic signed [WIDE_W-1:0] sliced_stride;
        logic                     axis_valid;
        logic signed [WIDE_W-1:0] base_offset;
        logic [WIDE_W-1:0]        total_elements;
        logic                     status;
        logic                     is_last;
    } out_item_t;

    // Axis after index normalization, as handed from front to back.
    typedef struct packed {
        logic [LEN_W-1:0]        start_c;
        logic [LEN_W-1:0]        stop_c;
        logic signed [IDX_W-1:0] stride;
        logic signed [IDX_W-1:0] step;
        logic                    too_many;
        logic                    last;
    } q_item_t;

    typedef struct packed {
        logic             push;
        logic             pop;
    } q_ctrl_t;

    typedef struct packed {
        logic             full;
        logic             empty;
    } q_stat_t;

endpackage

`default_nettype wire

[hdl/strided_slice_view_calculator_top.sv]
// Strided slice view calculator.
// Each transfer on the item channel describes one tensor axis (size, stride,
// slice start, stop and step); last_axis marks the final axis of a request.
// Each item yields exactly one transfer on the result channel, in order, with
// the sliced length and stride of that axis. The result of the last axis also
// carries the base offset, the total element count and the status of the
// whole request, after which the accumulated state is cleared.
// A front stage normalizes the indices and counts axes, a two-entry queue
// decouples it from the back end, which runs a one-bit-per-cycle divider for
// the sliced length and a shared multiplier for strides, offset and product.
// A non-empty axis passes from the front hold register through the queue to
// the back end, which loads it, runs the divider (31 quotient steps, then done),
// uses the multiplier for stride, offset and the low and high product halves
// and finishes; an empty slice or zero step skips the divider. The back end
// takes a new axis only when done with the last; the front and queue hold three more.
// When the receiver holds result_ready low, the finished result waits in the
// output register while the back end stops before its next result and the
// front keeps accepting until the queue and its own hold register are full.
// Reset (rst_n low) empties the queue, drops any pending results and returns
// the accumulators to offset zero, product one and no error.
`default_nettype none

module strided_slice_view_calculator_top
    import sscv_pkg::*;
(
    input  wire logic      clk,
    input  wire logic      rst_n,
    input  wire logic      item_valid,
    output logic           item_ready,
    input  wire in_item_t  item,
    output logic           result_valid,
    input  wire logic      result_ready,
    output out_item_t      result
);

    q_ctrl_t q_ctrl;
    q_stat_t q_stat;
    q_item_t q_push_data;
    q_item_t q_pop_data;
    logic    q_push;
    logic    q_pop;

    assign q_ctrl.push = q_push;
    assign q_ctrl.pop  = q_pop;

    sscv_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .item_valid (item_valid),
        .item_ready (item_ready),
        .item       (item),
        .q_stat     (q_stat),
        .q_push     (q_push),
        .q_data     (q_push_data)
    );

    sscv_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .ctrl      (q_ctrl),
        .push_data (q_push_data),
        .stat      (q_stat),
        .pop_data  (q_pop_data)
    );

    sscv_back u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .q_stat       (q_stat),
        .q_data       (q_pop_data),
        .q_pop        (q_pop),
        .result_valid (result_valid),
        .result_ready (result_ready),
        .result       (result)
    );

endmodule

`default_nettype wire

[hdl/sscv_queue.sv]
`default_nettype none

module sscv_queue
    import sscv_pkg::*;
(
    input  wire logic    clk,
    input  wire logic    rst_n,
    input  wire q_ctrl_t ctrl,
    input  wire q_item_t push_data,
    output q_stat_t      stat,
    output q_item_t      pop_data
);

    q_item_t             entry_reg [Q_DEPTH];
    logic [Q_PTR_W-1:0]  wr_ptr_reg;
    logic [Q_PTR_W-1:0]  rd_ptr_reg;
    logic [Q_CNT_W-1:0]  count_reg;
    logic                do_push;
    logic                do_pop;

    assign stat.full  = (count_reg == Q_CNT_W'(Q_DEPTH));
    assign stat.empty = (count_reg == '0);
    assign do_push    = ctrl.push && !stat.full;
    assign do_pop     = ctrl.pop && !stat.empty;
    assign pop_data   = entry_reg[rd_ptr_reg];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (do_push)
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            if (do_pop)
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            if (do_push && !do_pop)
                count_reg <= count_reg + 1'b1;
            else if (do_pop && !do_push)
                count_reg <= count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
            entry_reg[wr_ptr_reg] <= push_data;
    end

endmodule

`default_nettype wire

[hdl/sscv_front.sv]
`default_nettype none

module sscv_front
    import sscv_pkg::*;
(
    input  wire logic     clk,
    input  wire logic     rst_n,
    input  wire logic     item_valid,
    output logic          item_ready,
    input  wire in_item_t item,
    input  wire q_stat_t  q_stat,
    output logic          q_push,
    output q_item_t       q_data
);

    function automatic logic [LEN_W-1:0] clip_index(
        input logic signed [IDX_W-1:0] idx,
        input logic [LEN_W-1:0]        size
    );
        logic signed [IDX_W:0] wrapped;
        logic [LEN_W-1:0]      res;
        wrapped = (IDX_W+1)'(idx) + $signed({2'b00, size});
        if (idx[IDX_W-1])
        begin
            if (wrapped[IDX_W])
                res = '0;
            else
                res = wrapped[LEN_W-1:0];
        end
        else if (idx[LEN_W-1:0] > size)
            res = size;
        else
            res = idx[LEN_W-1:0];
        return res;
    endfunction

    logic             hold_valid_reg;
    in_item_t         hold_reg;
    logic             too_many_reg;
    logic [CNT_W-1:0] count_reg;
    logic             accept;
    logic             too_many;

    assign q_push     = hold_valid_reg && !q_stat.full;
    assign item_ready = !hold_valid_reg || q_push;
    assign accept     = item_valid && item_ready;
    assign too_many   = (count_reg >= CNT_W'(MAX_AXES));

    always_comb
    begin
        q_data.start_c  = clip_index(hold_reg.slice_start, hold_reg.axis_size);
        q_data.stop_c   = clip_index(hold_reg.slice_stop, hold_reg.axis_size);
        q_data.stride   = hold_reg.axis_stride;
        q_data.step     = hold_reg.slice_step;
        q_data.too_many = too_many_reg;
        q_data.last     = hold_reg.last_axis;
    end

    // The axis count follows the order of accepted transfers, so it is kept here.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hold_valid_reg <= 1'b0;
            count_reg      <= '0;
        end
        else
        begin
            if (accept)
            begin
                hold_valid_reg <= 1'b1;
                if (item.last_axis)
                    count_reg <= '0;
                else if (!too_many)
                    count_reg <= count_reg + 1'b1;
            end
            else if (q_push)
                hold_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            hold_reg     <= item;
            too_many_reg <= too_many;
        end
    end

endmodule

`default_nettype wire

[hdl/sscv_div.sv]
`default_nettype none

module sscv_div
    import sscv_pkg::*;
(
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             start,
    input  wire logic [LEN_W-1:0] dividend,
    input  wire logic [IDX_W-1:0] divisor,
    output logic                  done,
    output logic [LEN_W-1:0]      quotient
);

    // Restoring division, one quotient bit per cycle.
    logic                 busy_reg;
    logic                 done_reg;
    logic [DIV_CNT_W-1:0] cnt_reg;
    logic [LEN_W-1:0]     dq_reg;
    logic [IDX_W-1:0]     rem_reg;
    logic [IDX_W-1:0]     div_reg;
    logic [IDX_W:0]       shifted;
    logic [IDX_W+1:0]     trial;
    logic                 fits;

    assign shifted  = {rem_reg, dq_reg[LEN_W-1]};
    assign trial    = {1'b0, shifted} - {2'b00, div_reg};
    assign fits     = !trial[IDX_W+1];
    assign done     = done_reg;
    assign quotient = dq_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= DIV_CNT_W'(DIV_STEPS);
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg - 1'b1;
                if (cnt_reg == DIV_CNT_W'(1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            dq_reg  <= dividend;
            rem_reg <= '0;
            div_reg <= divisor;
        end
        else if (busy_reg)
        begin
            dq_reg <= {dq_reg[LEN_W-2:0], fits};
            if (fits)
                rem_reg <= trial[IDX_W-1:0];
            else
                rem_reg <= shifted[IDX_W-1:0];
        end
    end

endmodule

`default_nettype wire

[hdl/sscv_back.sv]
`default_nettype none

module sscv_back
    import sscv_pkg::*;
(
    input  wire logic    clk,
    input  wire logic    rst_n,
    input  wire q_stat_t q_stat,
    input  wire q_item_t q_data,
    output logic         q_pop,
    output logic         result_valid,
    input  wire logic    result_ready,
    output out_item_t    result
);

    typedef enum logic [7:0] {
        S_IDLE       = 8'b0000_0001,
        S_LOAD       = 8'b0000_0010,
        S_DIV        = 8'b0000_0100,
        S_MUL_STRIDE = 8'b0000_1000,
        S_MUL_OFFSET = 8'b0001_0000,
        S_MUL_LO     = 8'b0010_0000,
        S_MUL_HI     = 8'b0100_0000,
        S_FINISH     = 8'b1000_0000
    } state_t;

    state_t                  state_reg;
    state_t                  state_next;
    q_item_t                 item_reg;
    logic [LEN_W-1:0]        len_reg;
    logic signed [2*IDX_W+1:0] mul_reg;
    logic [WIDE_W-1:0]       stride_prod_reg;
    logic [WIDE_W-1:0]       off_prod_reg;
    logic [WIDE_W-2:0]       plo_reg;
    logic [WIDE_W-1:0]       offset_reg;
    logic [WIDE_W-1:0]       prod_reg;
    logic                    err_reg;
    logic                    out_valid_reg;
    out_item_t               out_reg;

    logic                    step_pos;
    logic                    step_neg;
    logic                    nonempty;
    logic [LEN_W-1:0]        dm1;
    logic [IDX_W-1:0]        div_n;
    logic                    div_start;
    logic                    div_done;
    logic [LEN_W-1:0]        div_q;
    logic signed [IDX_W:0]   mul_a;
    logic signed [IDX_W:0]   mul_b;
    logic signed [2*IDX_W+1:0] mul_p;
    logic                    mul_en;
    logic                    out_free;
    logic                    finish;
    logic                    err_pre;
    logic                    err_fin;
    logic                    ovf;
    logic [WIDE_W:0]         sum;
    logic [WIDE_W-1:0]       offset_new;
    logic [WIDE_W-1:0]       prod_new;
    out_item_t               out_next;

    // Length is ceil(d / n) = (d - 1) / n + 1 for a non-empty slice of span d.
    assign step_pos  = !item_reg.step[IDX_W-1] && (item_reg.step != '0);
    assign step_neg  = item_reg.step[IDX_W-1];
    assign nonempty  = (step_pos && (item_reg.start_c < item_reg.stop_c))
                    || (step_neg && (item_reg.start_c > item_reg.stop_c));
    assign dm1       = step_pos ? (item_reg.stop_c + ~item_reg.start_c)
                                : (item_reg.start_c + ~item_reg.stop_c);
    assign div_n     = step_pos ? item_reg.step : (-item_reg.step);
    assign div_start = (state_reg == S_LOAD) && nonempty;

    sscv_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (dm1),
        .divisor  (div_n),
        .done     (div_done),
        .quotient (div_q)
    );

    // One shared multiplier; the wide length product is split into two halves.
    always_comb
    begin
        mul_a  = '0;
        mul_b  = '0;
        mul_en = 1'b1;
        unique case (state_reg)
            S_MUL_STRIDE:
            begin
                mul_a = (IDX_W+1)'(item_reg.stride);
                mul_b = (IDX_W+1)'(item_reg.step);
            end
            S_MUL_OFFSET:
            begin
                mul_a = $signed({2'b00, item_reg.start_c});
                mul_b = (IDX_W+1)'(item_reg.stride);
            end
            S_MUL_LO:
            begin
                mul_a = $signed({1'b0, prod_reg[IDX_W-1:0]});
                mul_b = $signed({2'b00, len_reg});
            end
            S_MUL_HI:
            begin
                mul_a = $signed({1'b0, prod_reg[WIDE_W-1:IDX_W]});
                mul_b = $signed({2'b00, len_reg});
            end
            default:
            begin
                mul_en = 1'b0;
            end
        endcase
    end

    assign mul_p = mul_a * mul_b;

    always_comb
    begin
        err_pre    = err_reg || item_reg.too_many || (len_reg == '0);
        sum        = {2'b00, plo_reg}
                   + {1'b0, mul_reg[IDX_W-1:0], {IDX_W{1'b0}}};
        ovf        = (mul_reg[WIDE_W-2:IDX_W] != '0) || sum[WIDE_W];
        err_fin    = err_pre || ovf;
        offset_new = err_pre ? offset_reg : (offset_reg + off_prod_reg);
        prod_new   = err_fin ? prod_reg : sum[WIDE_W-1:0];

        out_next.sliced_length  = len_reg;
        out_next.sliced_stride  = stride_prod_reg;
        out_next.axis_valid     = (len_reg != '0);
        out_next.status         = item_reg.last && err_fin;
        out_next.is_last        = item_reg.last;
        if (item_reg.last && !err_fin)
        begin
            out_next.base_offset    = offset_new;
            out_next.total_elements = prod_new;
        end
        else
        begin
            out_next.base_offset    = '0;
            out_next.total_elements = '0;
        end
    end

    assign out_free     = !out_valid_reg || result_ready;
    assign finish       = (state_reg == S_FINISH) && out_free;
    assign q_pop        = (state_reg == S_IDLE) && !q_stat.empty;
    assign result_valid = out_valid_reg;
    assign result       = out_reg;

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (!q_stat.empty)
                    state_next = S_LOAD;
            end
            S_LOAD:
            begin
                state_next = nonempty ? S_DIV : S_MUL_STRIDE;
            end
            S_DIV:
            begin
                if (div_done)
                    state_next = S_MUL_STRIDE;
            end
            S_MUL_STRIDE: state_next = S_MUL_OFFSET;
            S_MUL_OFFSET: state_next = S_MUL_LO;
            S_MUL_LO:     state_next = S_MUL_HI;
            S_MUL_HI:     state_next = S_FINISH;
            S_FINISH:
            begin
                if (out_free)
                    state_next = S_IDLE;
            end
            default:      state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
            offset_reg    <= '0;
            prod_reg      <= WIDE_W'(1);
            err_reg       <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (finish)
                out_valid_reg <= 1'b1;
            else if (result_ready)
                out_valid_reg <= 1'b0;
            if (finish)
            begin
                if (item_reg.last)
                begin
                    offset_reg <= '0;
                    prod_reg   <= WIDE_W'(1);
                    err_reg    <= 1'b0;
                end
                else
                begin
                    offset_reg <= offset_new;
                    prod_reg   <= prod_new;
                    err_reg    <= err_fin;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (q_pop)
            item_reg <= q_data;
        if (state_reg == S_LOAD)
            len_reg <= '0;
        else if ((state_reg == S_DIV) && div_done)
            len_reg <= div_q + 1'b1;
        if (mul_en)
            mul_reg <= mul_p;
        if (state_reg == S_MUL_OFFSET)
            stride_prod_reg <= mul_reg[WIDE_W-1:0];
        if (state_reg == S_MUL_LO)
            off_prod_reg <= mul_reg[WIDE_W-1:0];
        if (state_reg == S_MUL_HI)
            plo_reg <= mul_reg[WIDE_W-2:0];
        if (finish)
            out_reg <= out_next;
    end

endmodule

`default_nettype wire

[dv/tb.sv]
`default_nettype none

module tb;
    import sscv_pkg::*;

    localparam int WATCHDOG_LIMIT = 4000;
    localparam int LONG_HOLD      = 300;
    localparam int RANDOM_ITEMS   = 824;
    localparam int CALM_ITEMS     = 120;

    logic      clk = 1'b0;
    logic      rst_n = 1'b0;
    logic      item_valid = 1'b0;
    logic      item_ready;
    in_item_t  item = '0;
    logic      result_valid;
    logic      result_ready = 1'b0;
    out_item_t result;

    strided_slice_view_calculator_top dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .item_valid   (item_valid),
        .item_ready   (item_ready),
        .item         (item),
        .result_valid (result_valid),
        .result_ready (result_ready),
        .result       (result)
    );

    always
    begin
        clk = 1'b0;
        #6;
        clk = 1'b1;
        #6;
    end

    // Predictor state for the request in progress.
    logic [63:0] offset_acc = 64'd0;
    logic [63:0] length_acc = 64'd1;
    bit          request_bad = 1'b0;
    int          axes_in_request = 0;

    out_item_t   due_results[$];
    int          mismatches = 0;
    int          axes_accepted = 0;
    int          results_seen = 0;
    int          requests_done = 0;
    int          requests_invalid = 0;
    int          empty_axes = 0;
    int          quiet_cycles = 0;

    bit          tx_idle = 1'b1;
    bit          rx_idle = 1'b1;
    bit          hold_toggle = 1'b0;
    bit          hold_served = 1'b0;
    int          rx_hold = 0;

    function automatic longint clamp_index(input longint idx, input longint size);
        longint v;
        v = idx;
        if (v < 0)
            v = v + size;
        if (v < 0)
            v = 0;
        if (v > size)
            v = size;
        return v;
    endfunction

    function automatic out_item_t predict_slice_result(input in_item_t a);
        longint      size;
        longint      stride;
        longint      lo;
        longint      hi;
        longint      step;
        longint      mag;
        longint      len;
        logic [63:0] ulen;
        bit          bad;
        out_item_t   r;
        size   = longint'(a.axis_size);
        stride = longint'(a.axis_stride);
        step   = longint'(a.slice_step);
        lo     = clamp_index(longint'(a.slice_start), size);
        hi     = clamp_index(longint'(a.slice_stop), size);
        len    = 0;
        bad    = 1'b0;
        // The axis counter saturates; the extra axis itself is still computed.
        if (axes_in_request >= MAX_AXES)
            bad = 1'b1;
        else
            axes_in_request++;
        if (step > 0)
        begin
            if (lo < hi)
                len = (hi - lo + step - 1) / step;
        end
        else if (step < 0)
        begin
            mag = -step;
            if (lo > hi)
                len = (lo - hi + mag - 1) / mag;
        end
        if (len == 0)
            bad = 1'b1;
        if (bad)
            request_bad = 1'b1;
        if (!request_bad)
        begin
            ulen = 64'(len);
            offset_acc = offset_acc + 64'(lo * stride);
            if (length_acc > 64'hFFFF_FFFF_FFFF_FFFF / ulen)
                request_bad = 1'b1;
            else
                length_acc = length_acc * ulen;
        end
        r = '0;
        r.sliced_length = len[LEN_W-1:0];
        r.sliced_stride = stride * step;
        r.axis_valid    = (len != 0);
        r.is_last       = a.last_axis;
        if (a.last_axis)
        begin
            if (request_bad)
                r.status = 1'b1;
            else
            begin
                r.base_offset    = offset_acc;
                r.total_elements = length_acc;
            end
            offset_acc      = 64'd0;
            length_acc      = 64'd1;
            request_bad     = 1'b0;
            axes_in_request = 0;
        end
        return r;
    endfunction

    always @(posedge clk)
    begin
        if (rst_n && item_valid && item_ready)
        begin
            due_results.push_back(predict_slice_result(item));
            axes_accepted++;
        end
    end

    always @(posedge clk)
    begin
        out_item_t want;
        if (rst_n && result_valid && result_ready)
        begin
            results_seen++;
            if (due_results.size() == 0)
            begin
                if (mismatches < 10)
                    $display("Unexpected result transfer: len %0d stride %0d last %0b",
                             result.sliced_length, result.sliced_stride, result.is_last);
                mismatches++;
            end
            else
            begin
                want = due_results.pop_front();
                if (want.axis_valid == 1'b0)
                    empty_axes++;
                if (want.is_last)
                begin
                    requests_done++;
                    if (want.status)
                        requests_invalid++;
                end
                if (result.sliced_length !== want.sliced_length ||
                    result.sliced_stride !== want.sliced_stride ||
                    result.axis_valid !== want.axis_valid ||
                    result.base_offset !== want.base_offset ||
                    result.total_elements !== want.total_elements ||
                    result.status !== want.status ||
                    result.is_last !== want.is_last)
                begin
                    if (mismatches < 10)
                    begin
                        $display("Result %0d mismatch", results_seen);
                        $display("  got:  len %0d stride %0d valid %0b off %0d total %0d st %0b last %0b",
                                 result.sliced_length, result.sliced_stride, result.axis_valid,
                                 result.base_offset, result.total_elements, result.status,
                                 result.is_last);
                        $display("  want: len %0d stride %0d valid %0b off %0d total %0d st %0b last %0b",
                                 want.sliced_length, want.sliced_stride, want.axis_valid,
                                 want.base_offset, want.total_elements, want.status,
                                 want.is_last);
                    end
                    mismatches++;
                end
            end
        end
    end

    // Receiver: short random stalls, plus one long hold-off on request.
    always @(posedge clk)
    begin
        if (hold_toggle != hold_served)
        begin
            hold_served = hold_toggle;
            rx_hold = LONG_HOLD;
        end
        else if (rx_hold == 0 && rx_idle && $urandom_range(0, 4) == 0)
            rx_hold = $urandom_range(1, 7);
        if (rx_hold > 0)
        begin
            rx_hold--;
            result_ready <= 1'b0;
        end
        else
            result_ready <= 1'b1;
    end

    always @(posedge clk)
    begin
        if (!rst_n || (item_valid && item_ready) || (result_valid && result_ready))
            quiet_cycles = 0;
        else
        begin
            quiet_cycles++;
            if (quiet_cycles >= WATCHDOG_LIMIT)
            begin
                $display("Watchdog: no transfer for %0d cycles", quiet_cycles);
                $display("TEST FAILED");
                $finish;
            end
        end
    end

    function automatic in_item_t make_axis(input logic [30:0] size, input logic [31:0] stride,
                                           input logic [31:0] start, input logic [31:0] stop,
                                           input logic [31:0] step, input bit last);
        in_item_t a;
        a.axis_size   = size;
        a.axis_stride = stride;
        a.slice_start = start;
        a.slice_stop  = stop;
        a.slice_step  = step;
        a.last_axis   = last;
        return a;
    endfunction

    // Offers one axis and returns right after the edge that accepts it.
    task automatic send_axis(input in_item_t a);
        int gap;
        if (tx_idle && $urandom_range(0, 3) == 0)
        begin
            gap = $urandom_range(1, 7);
            item_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        item       <= a;
        item_valid <= 1'b1;
        do
            @(posedge clk);
        while (!item_ready);
    endtask

    function automatic logic [30:0] pick_size();
        case ($urandom_range(0, 15))
            0:       return 31'h7FFF_FFFF;
            1:       return 31'($urandom());
            2:       return 31'($urandom_range(0, 4000));
            default: return 31'($urandom_range(0, 24));
        endcase
    endfunction

    function automatic logic [31:0] pick_index(input int size);
        case ($urandom_range(0, 9))
            0:       return $urandom();
            1:       return $urandom_range(0, 1) ? 32'h8000_0000 : 32'h7FFF_FFFF;
            default:
            begin
                if (size <= 4000)
                    return 32'($urandom_range(0, 2 * size + 4)) - 32'(size + 2);
                return $urandom();
            end
        endcase
    endfunction

    function automatic logic [31:0] pick_step();
        case ($urandom_range(0, 19))
            0:       return 32'd0;
            1:       return $urandom();
            2:       return $urandom_range(0, 1) ? 32'h8000_0000 : 32'h7FFF_FFFF;
            3, 4, 5: return 32'd0 - 32'($urandom_range(1, 4));
            default: return 32'($urandom_range(1, 4));
        endcase
    endfunction

    function automatic logic [31:0] pick_stride();
        if ($urandom_range(0, 3) == 0)
            return $urandom();
        return 32'($urandom_range(0, 200)) - 32'd100;
    endfunction

    task automatic test_basic_slices();
        send_axis(make_axis(10, 3, 0, 10, 1, 1'b0));
        send_axis(make_axis(10, -4, 9, -11, -1, 1'b0));
        send_axis(make_axis(7, 1, 1, 6, 2, 1'b1));
    endtask

    // Negative indices wrap by the size once, then everything is clipped.
    task automatic test_index_wrap();
        send_axis(make_axis(31'h7FFF_FFFF, 1, 32'h8000_0000, 32'h7FFF_FFFF,
                            32'h7FFF_FFFF, 1'b0));
        send_axis(make_axis(5, 7, -2, 100, 1, 1'b0));
        send_axis(make_axis(5, -1, 100, -100, 32'h8000_0000, 1'b0));
        send_axis(make_axis(1000, 32'h7FFF_FFFF, -1, -1000, -3, 1'b0));
        send_axis(make_axis(9, 32'h8000_0000, 0, 9, 7, 1'b1));
    endtask

    task automatic test_invalid_axes();
        send_axis(make_axis(6, 2, 0, 6, 0, 1'b0));
        send_axis(make_axis(6, 2, 4, 2, 1, 1'b0));
        send_axis(make_axis(0, 5, 0, 1, 1, 1'b1));
    endtask

    // Three large negative start*stride terms push the sum past -2^63.
    task automatic test_offset_wrap();
        for (int k = 0; k < 3; k++)
            send_axis(make_axis(31'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFE,
                                32'h7FFF_FFFF, 1, k == 2));
    endtask

    task automatic test_product_overflow();
        for (int k = 0; k < 3; k++)
            send_axis(make_axis(31'h7FFF_FFFF, 1, 0, 32'h7FFF_FFFF, 1, k == 2));
    endtask

    task automatic test_axis_limit();
        for (int k = 0; k <= MAX_AXES; k++)
            send_axis(make_axis(4, k + 1, 1, 4, 1, k == MAX_AXES));
    endtask

    // The receiver stalls while items keep coming, so the input side backs up.
    task automatic test_result_backpressure();
        hold_toggle <= ~hold_toggle;
        for (int k = 0; k < 6; k++)
            send_axis(make_axis(20, pick_stride(), pick_index(20), pick_index(20),
                                32'($urandom_range(1, 3)), k == 5));
    endtask

    task automatic test_random_requests();
        int       sent;
        int       n_axes;
        in_item_t a;
        logic [30:0] size;
        sent = 0;
        while (sent < RANDOM_ITEMS)
        begin
            if (sent >= RANDOM_ITEMS - CALM_ITEMS)
            begin
                tx_idle = 1'b0;
                rx_idle = 1'b0;
            end
            n_axes = ($urandom_range(0, 9) == 0) ? $urandom_range(MAX_AXES + 1, MAX_AXES + 3)
                                                 : $urandom_range(1, MAX_AXES);
            for (int k = 0; k < n_axes; k++)
            begin
                if ($urandom_range(0, 7) == 0)
                begin
                    a.axis_size   = 31'($urandom());
                    a.axis_stride = $urandom();
                    a.slice_start = $urandom();
                    a.slice_stop  = $urandom();
                    a.slice_step  = $urandom();
                end
                else
                begin
                    size = pick_size();
                    a = make_axis(size, pick_stride(), pick_index(int'(size)),
                                  pick_index(int'(size)), pick_step(), 1'b0);
                end
                a.last_axis = (k == n_axes - 1);
                send_axis(a);
                sent++;
            end
        end
    endtask

    initial
    begin
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_basic_slices();
        test_index_wrap();
        test_invalid_axes();
        test_offset_wrap();
        test_product_overflow();
        test_axis_limit();
        test_result_backpressure();
        test_random_requests();
        item_valid <= 1'b0;
        while (due_results.size() != 0)
            @(posedge clk);
        repeat (80) @(posedge clk);
        $display("Sent %0d axes in %0d slice requests; %0d axes were empty or had a zero step.",
                 axes_accepted, requests_done, empty_axes);
        $display("%0d requests ended with an invalid-parameter status, %0d mismatches.",
                 requests_invalid, mismatches);
        if (mismatches == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule

`default_nettype wire

[filelist.f]
hdl/sscv_pkg.sv
hdl/sscv_queue.sv
hdl/sscv_front.sv
hdl/sscv_div.sv
hdl/sscv_back.sv
hdl/strided_slice_view_calculator_top.sv
dv/tb.sv
